/* rtl/whp_pkg.sv */
`timescale 1ns / 1ps
// Package for the WAVE header parser: transaction types, status codes,
// magic words and byte-order helpers. Depends on nothing.
package whp_pkg;

	// Status codes of a result.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_RIFF     = 3'd1;
	localparam logic [2:0] ST_NO_WAVE     = 3'd2;
	localparam logic [2:0] ST_NO_FMT      = 3'd3;
	localparam logic [2:0] ST_NO_DATA     = 3'd4;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

	// Sample format classes.
	localparam logic [1:0] FMT_MONO8    = 2'd0;
	localparam logic [1:0] FMT_STEREO8  = 2'd1;
	localparam logic [1:0] FMT_MONO16   = 2'd2;
	localparam logic [1:0] FMT_STEREO16 = 2'd3;

	// Magic words as they appear in the byte stream, first byte high.
	localparam logic [31:0] MAGIC_RIFF = 32'h5249_4646;
	localparam logic [31:0] MAGIC_WAVE = 32'h5741_5645;
	localparam logic [31:0] MAGIC_FMT  = 32'h666D_7420;
	localparam logic [31:0] MAGIC_DATA = 32'h6461_7461;

	// Input transaction: one byte of the file.
	typedef struct packed {
		logic [7:0] byte_in;
		logic       last;
	} in_t;

	// Result transaction.
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  sample_format;
		logic [15:0] channels;
		logic [15:0] bits_per_sample;
		logic [31:0] sample_rate;
		logic [31:0] data_size;
		logic [31:0] data_offset;
		logic [31:0] riff_size;
		logic [15:0] format_tag;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
	} out_t;

	// Little-endian word from a window whose newest byte is lowest.
	function automatic logic [31:0] le32(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// Little-endian half word from the two newest bytes of a window.
	function automatic logic [15:0] le16(input logic [31:0] w);
		return {w[7:0], w[15:8]};
	endfunction

endpackage

/* rtl/wave_header_parser.sv */
`timescale 1ns / 1ps
// Top level of the WAVE header parser: byte channel in, one result per file out.
// Depends on whp_pkg, whp_core and whp_out_reg.
//
//   channel   handshake                   payload
//   item      item_valid / item_ready     whp_pkg::in_t  (byte_in, last)
//   result    result_valid / result_ready whp_pkg::out_t (status and fields)
//
// One byte is taken every cycle unless stalled; its result, if any, enters the
// result register next cycle. Bytes stall only while a result waits in that
// register and the consumer holds result_ready low. Reset (arst_n low) puts
// the parser at the start of a file and empties the result register.
module wave_header_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  whp_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_ready,
	output whp_pkg::out_t result
);

	logic          accept;
	logic          res_valid;
	whp_pkg::out_t res;

	// A byte transaction completes when the result register has room.
	assign accept = item_valid && item_ready;

	whp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	whp_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept && res_valid),
		.load_data    (res),
		.can_load     (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* rtl/whp_core.sv */
`timescale 1ns / 1ps
// Parser state, field capture and result formation for one byte per cycle while accept is high.
// Depends on whp_pkg.
module whp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  whp_pkg::in_t  item,
	output logic          res_valid,
	output whp_pkg::out_t res
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_SEARCH = 2'd1;
	localparam logic [1:0] PH_SIZE   = 2'd2;
	localparam logic [1:0] PH_SKIP   = 2'd3;

	logic [1:0]  phase_q, phase_n;
	logic [31:0] position_q, position_n, pos_inc;
	logic [31:0] window_q, window_n;
	logic [1:0]  size_count_q, size_count_n;
	logic [31:0] riff_size_q, riff_size_n;
	logic [15:0] format_tag_q, format_tag_n;
	logic [15:0] channels_q, channels_n;
	logic [31:0] rate_q, rate_n;
	logic [31:0] byte_rate_q, byte_rate_n;
	logic [15:0] block_align_q, block_align_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] data_size_q, data_size_n;
	logic [31:0] offset_q, offset_n;
	logic        done;
	logic [2:0]  st;
	logic        fmt_ok;

	// Next-state logic for one accepted byte.
	always_comb begin
		window_n      = {window_q[23:0], item.byte_in};
		phase_n       = phase_q;
		size_count_n  = size_count_q;
		riff_size_n   = riff_size_q;
		format_tag_n  = format_tag_q;
		channels_n    = channels_q;
		rate_n        = rate_q;
		byte_rate_n   = byte_rate_q;
		block_align_n = block_align_q;
		bits_n        = bits_q;
		data_size_n   = data_size_q;
		offset_n      = offset_q;
		done          = 1'b0;
		st            = whp_pkg::ST_OK;
		pos_inc       = (position_q == 32'hFFFF_FFFF) ? position_q : position_q + 32'd1;
		fmt_ok        = ((bits_q == 16'd8) || (bits_q == 16'd16)) &&
		                ((channels_q == 16'd1) || (channels_q == 16'd2));

		case (phase_q)
			PH_HEADER: begin
				case (position_q)
					32'd3: begin
						if (window_n != whp_pkg::MAGIC_RIFF) begin
							st   = whp_pkg::ST_NO_RIFF;
							done = 1'b1;
						end
					end
					32'd7:  riff_size_n = whp_pkg::le32(window_n);
					32'd11: begin
						if (window_n != whp_pkg::MAGIC_WAVE) begin
							st   = whp_pkg::ST_NO_WAVE;
							done = 1'b1;
						end
					end
					32'd15: begin
						if (window_n != whp_pkg::MAGIC_FMT) begin
							st   = whp_pkg::ST_NO_FMT;
							done = 1'b1;
						end
					end
					32'd21: format_tag_n  = whp_pkg::le16(window_n);
					32'd23: channels_n    = whp_pkg::le16(window_n);
					32'd27: rate_n        = whp_pkg::le32(window_n);
					32'd31: byte_rate_n   = whp_pkg::le32(window_n);
					32'd33: block_align_n = whp_pkg::le16(window_n);
					32'd35: begin
						bits_n  = whp_pkg::le16(window_n);
						phase_n = PH_SEARCH;
					end
					default: ;
				endcase
			end
			PH_SEARCH: begin
				// The window must lie wholly past the header.
				if ((position_q >= 32'd39) && !item.last &&
				    (window_n == whp_pkg::MAGIC_DATA)) begin
					phase_n      = PH_SIZE;
					size_count_n = 2'd0;
				end
			end
			PH_SIZE: begin
				if (size_count_q == 2'd3) begin
					data_size_n = whp_pkg::le32(window_n);
					offset_n    = pos_inc;
					st          = fmt_ok ? whp_pkg::ST_OK : whp_pkg::ST_UNSUPPORTED;
					done        = 1'b1;
				end else begin
					size_count_n = size_count_q + 2'd1;
				end
			end
			default: ;
		endcase

		// Result formation: a finished header, or an end before one.
		res_valid = 1'b0;
		res       = '0;
		if (done) begin
			phase_n   = PH_SKIP;
			res_valid = 1'b1;
		end else if (item.last && (phase_n != PH_SKIP)) begin
			data_size_n = '0;
			offset_n    = '0;
			st          = whp_pkg::ST_NO_DATA;
			res_valid   = 1'b1;
		end
		res.status          = st;
		res.channels        = channels_n;
		res.bits_per_sample = bits_n;
		res.sample_rate     = rate_n;
		res.data_size       = data_size_n;
		res.data_offset     = offset_n;
		res.riff_size       = riff_size_n;
		res.format_tag      = format_tag_n;
		res.byte_rate       = byte_rate_n;
		res.block_align     = block_align_n;
		if (st == whp_pkg::ST_OK) begin
			case ({bits_n == 16'd16, channels_n == 16'd2})
				2'b00:   res.sample_format = whp_pkg::FMT_MONO8;
				2'b01:   res.sample_format = whp_pkg::FMT_STEREO8;
				2'b10:   res.sample_format = whp_pkg::FMT_MONO16;
				default: res.sample_format = whp_pkg::FMT_STEREO16;
			endcase
		end
		position_n = pos_inc;

		// The last byte of a file re-arms the parser.
		if (item.last) begin
			phase_n       = PH_HEADER;
			position_n    = '0;
			window_n      = '0;
			size_count_n  = '0;
			riff_size_n   = '0;
			format_tag_n  = '0;
			channels_n    = '0;
			rate_n        = '0;
			byte_rate_n   = '0;
			block_align_n = '0;
			bits_n        = '0;
			data_size_n   = '0;
			offset_n      = '0;
		end
	end

	// Parser state registers, updated on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			position_q    <= '0;
			window_q      <= '0;
			size_count_q  <= '0;
			riff_size_q   <= '0;
			format_tag_q  <= '0;
			channels_q    <= '0;
			rate_q        <= '0;
			byte_rate_q   <= '0;
			block_align_q <= '0;
			bits_q        <= '0;
			data_size_q   <= '0;
			offset_q      <= '0;
		end else if (accept) begin
			phase_q       <= phase_n;
			position_q    <= position_n;
			window_q      <= window_n;
			size_count_q  <= size_count_n;
			riff_size_q   <= riff_size_n;
			format_tag_q  <= format_tag_n;
			channels_q    <= channels_n;
			rate_q        <= rate_n;
			byte_rate_q   <= byte_rate_n;
			block_align_q <= block_align_n;
			bits_q        <= bits_n;
			data_size_q   <= data_size_n;
			offset_q      <= offset_n;
		end
	end

endmodule

/* rtl/whp_out_reg.sv */
`timescale 1ns / 1ps
// Result register with valid/ready handshake toward the consumer.
// Depends on whp_pkg.
module whp_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  whp_pkg::out_t load_data,
	output logic          can_load,
	output logic          result_valid,
	input  logic          result_ready,
	output whp_pkg::out_t result
);

	logic          valid_q;
	whp_pkg::out_t data_q;

	// A new result may enter when the register is empty or being drained.
	assign can_load     = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// Payload holds until a new result is loaded.
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= load_data;
		end
	end

endmodule

/* verif/tb_wave_header_parser.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wave_header_parser: byte-level WAVE files, directed then random.
// Depends on whp_pkg and the wave_header_parser RTL; a parser model predicts each result.
module tb_wave_header_parser;

	localparam int HALF_PERIOD    = 1;
	localparam int RESET_CYCLES   = 6;
	localparam int LIMIT_CYCLES   = 200_000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int LONG_STALL     = 400;
	localparam int TOTAL_BYTES    = 1100;
	localparam int MIN_RAND_FILES = 8;
	localparam int MAX_PRINTS     = 40;
	localparam int N_DIRECTED     = 20;

	// How the header fields other than channels and bits are filled.
	localparam int FILL_ZERO = 0;
	localparam int FILL_ONES = 1;
	localparam int FILL_RAND = 2;

	// Content of the junk between the fmt chunk and the data tag.
	localparam int PAD_RAND = 0;
	localparam int PAD_TA   = 1;	// "ta" right after the header completes a false tag
	localparam int PAD_D    = 2;	// run of 'd' bytes ahead of the real tag

	typedef enum logic [1:0] {HDR_FIELDS, TAG_HUNT, SIZE_READ, DRAIN} parse_phase_t;
	typedef enum {RX_SLOW, TX_SLOW, NO_IDLE} idle_mode_t;

	// One file to send: header contents, layout and corruption.
	typedef struct {
		logic [31:0] chans;
		logic [31:0] bits;
		int          fill;
		int          pad_len;
		int          pad_kind;
		int          tail_len;
		int          cut_len;	// zero keeps the whole file
		int          bad_at;	// negative keeps every magic byte intact
		bit          typed;
		logic [2:0]  typed_status;
	} wav_case_t;

	logic           clk          = 1'b0;
	logic           arst_n       = 1'b0;
	logic           item_valid   = 1'b0;
	logic           item_ready;
	whp_pkg::in_t   item         = '0;
	logic           result_valid;
	logic           result_ready = 1'b0;
	whp_pkg::out_t  result;

	// Parser model state.
	parse_phase_t   parse_phase;
	logic [31:0]    byte_pos;
	logic [31:0]    tail_window;
	logic [1:0]     size_bytes;
	whp_pkg::out_t  captured;

	whp_pkg::out_t  expected_results[$];
	logic [7:0]     file_bytes[$];
	wav_case_t      directed_files[N_DIRECTED];
	bit             use_typed;
	whp_pkg::out_t  typed_result;
	idle_mode_t     idle_mode   = RX_SLOW;
	int             tx_idle_pct = 15;
	int             rx_idle_pct = 73;
	bit             long_stall_done;
	int             mismatches;
	int             results_checked;
	int             bytes_sent;
	int             rand_files;
	int             cycle_count;
	int             status_seen[8];

	wave_header_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #HALF_PERIOD clk = ~clk;

	// Parser model: back to the start of a file.
	function automatic void clear_parser();
		parse_phase = HDR_FIELDS;
		byte_pos    = '0;
		tail_window = '0;
		size_bytes  = '0;
		captured    = '0;
	endfunction

	// Reverses the byte order of the n newest bytes of a window.
	function automatic logic [31:0] from_le(input logic [31:0] w, input int n);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < n; i++) begin
			r[8*i +: 8] = w[8*(n-1-i) +: 8];
		end
		return r;
	endfunction

	// Advances the parser model by one byte; returns 1 when that byte yields a result.
	function automatic bit predict_byte(input whp_pkg::in_t it, output whp_pkg::out_t res);
		logic [31:0] p;
		logic [2:0]  st;
		bit          done;
		bit          emit;
		bit          fmt_ok;
		p    = byte_pos;
		st   = whp_pkg::ST_OK;
		done = 1'b0;
		emit = 1'b0;
		res  = '0;
		tail_window = {tail_window[23:0], it.byte_in};
		case (parse_phase)
			HDR_FIELDS: begin
				case (p)
					32'd3: if (tail_window != whp_pkg::MAGIC_RIFF) begin
						st = whp_pkg::ST_NO_RIFF;
						done = 1'b1;
					end
					32'd7:  captured.riff_size = from_le(tail_window, 4);
					32'd11: if (tail_window != whp_pkg::MAGIC_WAVE) begin
						st = whp_pkg::ST_NO_WAVE;
						done = 1'b1;
					end
					32'd15: if (tail_window != whp_pkg::MAGIC_FMT) begin
						st = whp_pkg::ST_NO_FMT;
						done = 1'b1;
					end
					32'd21: captured.format_tag = 16'(from_le(tail_window, 2));
					32'd23: captured.channels = 16'(from_le(tail_window, 2));
					32'd27: captured.sample_rate = from_le(tail_window, 4);
					32'd31: captured.byte_rate = from_le(tail_window, 4);
					32'd33: captured.block_align = 16'(from_le(tail_window, 2));
					32'd35: begin
						captured.bits_per_sample = 16'(from_le(tail_window, 2));
						parse_phase = TAG_HUNT;
					end
					default: ;
				endcase
			end
			TAG_HUNT: begin
				// The tag only counts when the window holds no header byte.
				if (p >= 32'd39 && !it.last && tail_window == whp_pkg::MAGIC_DATA) begin
					parse_phase = SIZE_READ;
					size_bytes = '0;
				end
			end
			SIZE_READ: begin
				if (size_bytes == 2'd3) begin
					captured.data_size = from_le(tail_window, 4);
					captured.data_offset = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
					fmt_ok = (captured.bits_per_sample == 16'd8 ||
						captured.bits_per_sample == 16'd16) &&
						(captured.channels == 16'd1 || captured.channels == 16'd2);
					st = fmt_ok ? whp_pkg::ST_OK : whp_pkg::ST_UNSUPPORTED;
					done = 1'b1;
				end else begin
					size_bytes = size_bytes + 2'd1;
				end
			end
			default: ;
		endcase

		// A finished file wins over the end flag; otherwise an early end reports no data.
		if (done) begin
			emit = 1'b1;
			parse_phase = DRAIN;
		end else if (it.last && parse_phase != DRAIN) begin
			captured.data_size = '0;
			captured.data_offset = '0;
			st = whp_pkg::ST_NO_DATA;
			emit = 1'b1;
		end
		if (emit) begin
			res = captured;
			res.status = st;
			res.sample_format = whp_pkg::FMT_MONO8;
			if (st == whp_pkg::ST_OK) begin
				if (captured.bits_per_sample == 16'd16) begin
					res.sample_format = (captured.channels == 16'd2) ?
						whp_pkg::FMT_STEREO16 : whp_pkg::FMT_MONO16;
				end else begin
					res.sample_format = (captured.channels == 16'd2) ?
						whp_pkg::FMT_STEREO8 : whp_pkg::FMT_MONO8;
				end
			end
		end

		if (byte_pos != 32'hFFFF_FFFF) begin
			byte_pos = byte_pos + 32'd1;
		end
		if (it.last) begin
			clear_parser();
		end
		return emit;
	endfunction

	function automatic logic [31:0] pick_field(input int fill);
		case (fill)
			FILL_ZERO: return '0;
			FILL_ONES: return '1;
			default:   return $urandom;
		endcase
	endfunction

	function automatic void push_bytes(input logic [31:0] w, input int n, input bit msb_first);
		for (int i = 0; i < n; i++) begin
			file_bytes.push_back(msb_first ? w[8*(n-1-i) +: 8] : w[8*i +: 8]);
		end
	endfunction

	// Lays out one file in file_bytes, then corrupts and truncates it as asked.
	function automatic void build_wav(input wav_case_t c);
		file_bytes.delete();
		push_bytes(whp_pkg::MAGIC_RIFF, 4, 1'b1);
		push_bytes(pick_field(c.fill), 4, 1'b0);
		push_bytes(whp_pkg::MAGIC_WAVE, 4, 1'b1);
		push_bytes(whp_pkg::MAGIC_FMT, 4, 1'b1);
		push_bytes(pick_field(c.fill), 4, 1'b0);
		push_bytes(pick_field(c.fill), 2, 1'b0);
		push_bytes(c.chans, 2, 1'b0);
		push_bytes(pick_field(c.fill), 4, 1'b0);
		push_bytes(pick_field(c.fill), 4, 1'b0);
		push_bytes(pick_field(c.fill), 2, 1'b0);
		push_bytes(c.bits, 2, 1'b0);
		for (int i = 0; i < c.pad_len; i++) begin
			if (c.pad_kind == PAD_TA && i < 2) begin
				file_bytes.push_back((i == 0) ? 8'h74 : 8'h61);
			end else if (c.pad_kind == PAD_D) begin
				file_bytes.push_back(8'h64);
			end else begin
				file_bytes.push_back(8'($urandom));
			end
		end
		push_bytes(whp_pkg::MAGIC_DATA, 4, 1'b1);
		push_bytes(pick_field(c.fill), 4, 1'b0);
		for (int i = 0; i < c.tail_len; i++) begin
			file_bytes.push_back(8'($urandom));
		end
		if (c.bad_at >= 0 && c.bad_at < file_bytes.size()) begin
			file_bytes[c.bad_at] = file_bytes[c.bad_at] ^ 8'($urandom_range(1, 255));
		end
		if (c.cut_len > 0) begin
			while (file_bytes.size() > c.cut_len) begin
				void'(file_bytes.pop_back());
			end
		end
	endfunction

	task automatic apply_mode(input idle_mode_t m);
		idle_mode = m;
		case (m)
			RX_SLOW: begin
				tx_idle_pct = 15;
				rx_idle_pct = 73;
			end
			TX_SLOW: begin
				tx_idle_pct = 73;
				rx_idle_pct = 15;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
		endcase
	endtask

	// Idling scheme follows how far the run has got, in bytes.
	task automatic update_mode();
		if (bytes_sent < TOTAL_BYTES / 3) begin
			apply_mode(RX_SLOW);
		end else if (bytes_sent < 2 * TOTAL_BYTES / 3) begin
			apply_mode(TX_SLOW);
		end else begin
			apply_mode(NO_IDLE);
		end
	endtask

	// Offers one byte, waits for its transaction and records what it should produce.
	task automatic send_byte(input logic [7:0] b, input bit is_last);
		whp_pkg::in_t  it;
		whp_pkg::out_t res;
		it.byte_in = b;
		it.last = is_last;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		bytes_sent++;
		if (predict_byte(it, res)) begin
			if (use_typed) begin
				res = typed_result;
			end
			expected_results.push_back(res);
			status_seen[res.status]++;
		end
	endtask

	task automatic send_file();
		update_mode();
		for (int i = 0; i < file_bytes.size(); i++) begin
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("%0t: mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
				$realtime, results_checked, what, got, want);
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(name, got, want);
		end
	endtask

	// Result checker: every output transaction against the oldest expectation.
	always @(posedge clk) begin
		whp_pkg::out_t want;
		if (arst_n && result_valid && result_ready) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending, status",
					32'(result.status), '0);
			end else begin
				want = expected_results.pop_front();
				compare_field("status", 32'(result.status), 32'(want.status));
				compare_field("sample_format", 32'(result.sample_format),
					32'(want.sample_format));
				compare_field("channels", 32'(result.channels), 32'(want.channels));
				compare_field("bits_per_sample", 32'(result.bits_per_sample),
					32'(want.bits_per_sample));
				compare_field("sample_rate", result.sample_rate, want.sample_rate);
				compare_field("data_size", result.data_size, want.data_size);
				compare_field("data_offset", result.data_offset, want.data_offset);
				compare_field("riff_size", result.riff_size, want.riff_size);
				compare_field("format_tag", 32'(result.format_tag), 32'(want.format_tag));
				compare_field("byte_rate", result.byte_rate, want.byte_rate);
				compare_field("block_align", 32'(result.block_align),
					32'(want.block_align));
			end
		end
	end

	// Output side: random stalls, plus one long hold-off once idling stops.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_mode == NO_IDLE && !long_stall_done) begin
				long_stall_done = 1'b1;
				result_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Stimulus: directed files, then random files, under three idling schemes in turn.
	initial begin
		wav_case_t c;
		int        pick;
		int        n_dir;

		// chans, bits, fill, pad, pad kind, tail, cut, bad byte, typed, status
		directed_files = '{
			'{32'd1, 32'd8, FILL_RAND, 0, PAD_RAND, 0, 4, 0, 1'b1, whp_pkg::ST_NO_RIFF},
			'{32'd1, 32'd8, FILL_RAND, 0, PAD_RAND, 0, 1, -1, 1'b1, whp_pkg::ST_NO_DATA},
			'{32'd1, 32'd8, FILL_RAND, 2, PAD_RAND, 3, 0, 3, 1'b1, whp_pkg::ST_NO_RIFF},
			'{32'd2, 32'd16, FILL_RAND, 2, PAD_RAND, 2, 0, 9, 1'b0, whp_pkg::ST_OK},
			'{32'd2, 32'd16, FILL_RAND, 2, PAD_RAND, 2, 0, 15, 1'b0, whp_pkg::ST_OK},
			'{32'd1, 32'd8, FILL_ZERO, 0, PAD_RAND, 0, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd2, 32'd8, FILL_ONES, 1, PAD_RAND, 1, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd1, 32'd16, FILL_RAND, 3, PAD_RAND, 2, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd2, 32'd16, FILL_ONES, 0, PAD_RAND, 0, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd3, 32'd16, FILL_RAND, 2, PAD_RAND, 1, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd2, 32'd24, FILL_RAND, 2, PAD_RAND, 1, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd0, 32'd0, FILL_ZERO, 1, PAD_RAND, 1, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'hFFFF, 32'hFFFF, FILL_ONES, 1, PAD_RAND, 1, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd1, 32'd16, FILL_RAND, 2, PAD_RAND, 2, 20, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd2, 32'd8, FILL_RAND, 2, PAD_RAND, 2, 36, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd2, 32'd16, FILL_RAND, 3, PAD_RAND, 2, 43, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd1, 32'd8, FILL_RAND, 1, PAD_RAND, 2, 43, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd1, 32'h6164, FILL_RAND, 4, PAD_TA, 1, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd2, 32'd16, FILL_RAND, 5, PAD_D, 2, 0, -1, 1'b0, whp_pkg::ST_OK},
			'{32'd2, 32'd8, FILL_RAND, 2, PAD_RAND, 3, 0, 38, 1'b0, whp_pkg::ST_OK}
		};

		clear_parser();
		apply_mode(RX_SLOW);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed files: typed rows carry their own expected result.
		n_dir = 0;
		foreach (directed_files[i]) begin
			c = directed_files[i];
			use_typed = c.typed;
			typed_result = '0;
			typed_result.status = c.typed_status;
			build_wav(c);
			send_file();
			n_dir++;
		end
		use_typed = 1'b0;

		// Random files: mostly well-formed with random content, else cut, broken or noise.
		while (bytes_sent < TOTAL_BYTES || rand_files < MIN_RAND_FILES) begin
			pick = $urandom_range(0, 99);
			c.chans = ($urandom_range(0, 9) < 4) ? 32'd1 :
				($urandom_range(0, 5) < 5) ? 32'd2 : 32'($urandom_range(0, 65535));
			c.bits = ($urandom_range(0, 9) < 4) ? 32'd8 :
				($urandom_range(0, 5) < 5) ? 32'd16 : 32'($urandom_range(0, 65535));
			c.fill = ($urandom_range(0, 9) == 0) ?
				$urandom_range(FILL_ZERO, FILL_ONES) : FILL_RAND;
			c.pad_len = $urandom_range(0, 6);
			c.pad_kind = (c.pad_len >= 2) ? $urandom_range(PAD_RAND, PAD_D) : PAD_RAND;
			c.tail_len = $urandom_range(0, 4);
			c.cut_len = 0;
			c.bad_at = -1;
			c.typed = 1'b0;
			c.typed_status = whp_pkg::ST_OK;
			if (pick >= 70 && pick < 85) begin
				c.cut_len = $urandom_range(1, 44 + c.pad_len + c.tail_len);
			end else if (pick >= 85 && pick < 93) begin
				case ($urandom_range(0, 3))
					0: c.bad_at = $urandom_range(0, 3);
					1: c.bad_at = $urandom_range(8, 11);
					2: c.bad_at = $urandom_range(12, 15);
					default: c.bad_at = 36 + c.pad_len + $urandom_range(0, 3);
				endcase
			end
			build_wav(c);
			if (pick >= 93) begin
				file_bytes.delete();
				repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom));
			end
			send_file();
			rand_files++;
		end
		item_valid <= 1'b0;

		// Drain, then a few quiet cycles to catch any stray result.
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch("results still pending at end", expected_results.size(), '0);
		end

		$display("Sent %0d directed and %0d random files, %0d bytes; %0d results checked.",
			n_dir, rand_files, bytes_sent, results_checked);
		$display("Status mix: ok %0d, no RIFF %0d, no WAVE %0d, no fmt %0d,",
			status_seen[whp_pkg::ST_OK], status_seen[whp_pkg::ST_NO_RIFF],
			status_seen[whp_pkg::ST_NO_WAVE], status_seen[whp_pkg::ST_NO_FMT]);
		$display("  no data %0d, unsupported %0d.",
			status_seen[whp_pkg::ST_NO_DATA], status_seen[whp_pkg::ST_UNSUPPORTED]);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
